FILE: sv/hrsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and match strings for the request stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

   // parser phases
   localparam logic [3:0] PH_METHOD_FIRST = 4'd0;
   localparam logic [3:0] PH_M_GET        = 4'd1;
   localparam logic [3:0] PH_M_HEAD       = 4'd2;
   localparam logic [3:0] PH_M_POST       = 4'd3;
   localparam logic [3:0] PH_TARGET_FIRST = 4'd4;
   localparam logic [3:0] PH_TARGET       = 4'd5;
   localparam logic [3:0] PH_PROTO        = 4'd6;
   localparam logic [3:0] PH_LINE_START   = 4'd7;
   localparam logic [3:0] PH_NAME         = 4'd8;
   localparam logic [3:0] PH_OWS          = 4'd9;
   localparam logic [3:0] PH_VALUE        = 4'd10;
   localparam logic [3:0] PH_BODY_FIRST   = 4'd11;
   localparam logic [3:0] PH_BODY         = 4'd12;
   localparam logic [3:0] PH_ERROR        = 4'd13;

   // field tags
   localparam logic [2:0] KIND_SKIP   = 3'd0;
   localparam logic [2:0] KIND_METHOD = 3'd1;
   localparam logic [2:0] KIND_TARGET = 3'd2;
   localparam logic [2:0] KIND_NAME   = 3'd3;
   localparam logic [2:0] KIND_VALUE  = 3'd4;
   localparam logic [2:0] KIND_BODY   = 3'd5;

   // final status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_NOT_IMPL = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   // method codes
   localparam logic [1:0] METHOD_NONE = 2'd0;

   // message length and protocol string
   localparam int         LEN_W          = 5;
   localparam logic [4:0] MIN_LENGTH     = 5'd16;
   localparam logic [3:0] PROTO_LAST_POS = 4'd9;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_P     = 8'h50;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } hrsp_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] field_kind;
      logic       field_start;
      logic [1:0] method_code;
      logic       status_valid;
      logic [1:0] status_code;
   } hrsp_result_type;

   // last position of each method word, trailing space included
   function automatic logic [3:0] method_last_pos(input logic [1:0] idx);
      logic [3:0] pos;
      case (idx)
         2'd0:    pos = 4'd3;
         default: pos = 4'd4;
      endcase
      return pos;
   endfunction

   // expected byte of GET / HEAD / POST followed by a space
   function automatic logic [7:0] method_char(input logic [1:0] idx,
                                              input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (idx)
         2'd0: begin
            case (pos)
               4'd0:    ch = "G";
               4'd1:    ch = "E";
               4'd2:    ch = "T";
               4'd3:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         2'd1: begin
            case (pos)
               4'd0:    ch = "H";
               4'd1:    ch = "E";
               4'd2:    ch = "A";
               4'd3:    ch = "D";
               4'd4:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (pos)
               4'd0:    ch = "P";
               4'd1:    ch = "O";
               4'd2:    ch = "S";
               4'd3:    ch = "T";
               4'd4:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

   // expected byte of the protocol string with its line end
   function automatic logic [7:0] proto_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = "H";
         4'd1:    ch = "T";
         4'd2:    ch = "T";
         4'd3:    ch = "P";
         4'd4:    ch = "/";
         4'd5:    ch = "1";
         4'd6:    ch = ".";
         4'd7:    ch = "1";
         4'd8:    ch = CHAR_CR;
         4'd9:    ch = CHAR_LF;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

FILE: sv/hrsp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_req_if
// Byte request channel: valid, ready, data byte and last-byte flag.
// ----------------------------------------------------------------------------
interface hrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/hrsp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_rsp_if
// Tagged byte result channel with status fields.
// ----------------------------------------------------------------------------
interface hrsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] field_kind;
   logic       field_start;
   logic [1:0] method_code;
   logic       status_valid;
   logic [1:0] status_code;

   modport source (output valid, output out_byte, output field_kind, output field_start,
                   output method_code, output status_valid, output status_code,
                   input ready);
   modport sink   (input valid, input out_byte, input field_kind, input field_start,
                   input method_code, input status_valid, input status_code,
                   output ready);
endinterface
`default_nettype wire

FILE: sv/http_request_stream_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_stream_parser_core
// Request byte stream parser that tags each byte with its field.
// ----------------------------------------------------------------------------
// Takes one byte of a request message per cycle while the result side keeps
// up, and returns it tagged as method, target, header name, header value,
// body or skipped, with the method code once known and the final status on
// the last byte. A byte passes through an input register and then a result
// register, whose contents drive the channel; a stalled sink holds a byte
// in either register. The sustained rate is one byte per cycle while the
// sink takes results. A request is accepted while an earlier result still
// waits at the output, and the block stalls only when both registers are
// full.
module http_request_stream_parser_core (
   input  wire logic  clock,
   input  wire logic  reset,
   hrsp_req_if.sink   req_if,
   hrsp_rsp_if.source rsp_if
);
   import hrsp_pkg::*;

   logic            can_take;
   logic            advance;
   hrsp_item_type   item;
   hrsp_result_type result;

   // input register
   hrsp_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .can_take (can_take),
      .advance  (advance),
      .item     (item)
   );

   // parser state machine
   hrsp_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   // result register
   hrsp_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_take (can_take),
      .rsp_if   (rsp_if)
   );
endmodule
`default_nettype wire

FILE: sv/hrsp_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_in_stage
// Input register: holds one request until the parser step takes it.
// ----------------------------------------------------------------------------
module hrsp_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   hrsp_req_if.sink                    req_if,
   input  wire logic                   can_take,
   output      logic                   advance,
   output      hrsp_pkg::hrsp_item_type item
);
   import hrsp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   hrsp_item_type item_ff;
   logic          accept;

   // handshake: take a new request when empty or when the held one moves on
   assign advance      = valid_ff && can_take;
   assign req_if.ready = !valid_ff || can_take;
   assign accept       = req_if.valid && req_if.ready;
   assign valid_in     = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign item         = item_ff;

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.last_byte <= req_if.last_byte;
      end
   end
endmodule
`default_nettype wire

FILE: sv/hrsp_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_fsm
// Parser state machine: tags one byte per step and tracks the final status.
// ----------------------------------------------------------------------------
module hrsp_fsm (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire hrsp_pkg::hrsp_item_type  item,
   output      hrsp_pkg::hrsp_result_type result
);
   import hrsp_pkg::*;

   logic [3:0]       phase_ff, phase_in;
   logic [3:0]       match_ff, match_in;
   logic [1:0]       method_ff, method_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [1:0]       err_code_ff, err_code_in;
   logic             err_flag_ff, err_flag_in;
   logic             value_done_ff, value_done_in;
   logic             skip_next_ff, skip_next_in;

   logic [1:0] meth_idx;
   logic [3:0] meth_last;
   logic [7:0] meth_char;
   logic [7:0] prot_char;
   logic       fail_now;
   logic [1:0] fail_code;
   logic [2:0] kind;
   logic       start;
   logic [1:0] status;
   logic [7:0] b;

   assign b         = item.data_byte;
   assign meth_idx  = 2'(phase_ff - PH_M_GET);
   assign meth_last = method_last_pos(meth_idx);
   assign meth_char = method_char(meth_idx, match_ff);
   assign prot_char = proto_char(match_ff);

   // next state and byte tag
   always_comb begin
      phase_in      = phase_ff;
      match_in      = match_ff;
      method_in     = method_ff;
      err_code_in   = err_code_ff;
      err_flag_in   = err_flag_ff;
      value_done_in = value_done_ff;
      skip_next_in  = skip_next_ff;
      length_in     = (length_ff < MIN_LENGTH) ? LEN_W'(length_ff + 1'b1) : length_ff;
      kind          = KIND_SKIP;
      start         = 1'b0;
      fail_now      = 1'b0;
      fail_code     = ST_OK;
      status        = ST_OK;

      if (skip_next_ff) begin
         // byte after a carriage return passes unchecked
         skip_next_in = 1'b0;
      end else begin
         unique case (phase_ff) inside
            PH_METHOD_FIRST: begin
               if (b == CHAR_G || b == CHAR_H || b == CHAR_P) begin
                  phase_in = (b == CHAR_G) ? PH_M_GET : ((b == CHAR_H) ? PH_M_HEAD : PH_M_POST);
                  match_in = 4'd1;
                  kind     = KIND_METHOD;
                  start    = 1'b1;
               end else begin
                  fail_now  = 1'b1;
                  fail_code = ST_NOT_IMPL;
               end
            end
            PH_M_GET, PH_M_HEAD, PH_M_POST: begin
               if (match_ff > meth_last || b != meth_char) begin
                  fail_now  = 1'b1;
                  fail_code = ST_NOT_IMPL;
               end else if (match_ff == meth_last) begin
                  method_in = 2'(meth_idx + 2'd1);
                  match_in  = 4'd0;
                  phase_in  = PH_TARGET_FIRST;
               end else begin
                  match_in = 4'(match_ff + 4'd1);
                  kind     = KIND_METHOD;
               end
            end
            PH_TARGET_FIRST: begin
               if (b == CHAR_SPACE) begin
                  fail_now  = 1'b1;
                  fail_code = ST_BAD;
               end else begin
                  kind     = KIND_TARGET;
                  start    = 1'b1;
                  phase_in = PH_TARGET;
               end
            end
            PH_TARGET: begin
               if (b == CHAR_SPACE) begin
                  phase_in = PH_PROTO;
                  match_in = 4'd0;
               end else begin
                  kind = KIND_TARGET;
               end
            end
            PH_PROTO: begin
               if (match_ff > PROTO_LAST_POS || b != prot_char) begin
                  fail_now  = 1'b1;
                  fail_code = ST_BAD;
               end else if (match_ff == PROTO_LAST_POS) begin
                  match_in = 4'd0;
                  phase_in = PH_LINE_START;
               end else begin
                  match_in = 4'(match_ff + 4'd1);
               end
            end
            PH_LINE_START: begin
               if (b == CHAR_CR) begin
                  skip_next_in = 1'b1;
                  phase_in     = PH_BODY_FIRST;
               end else if (b == CHAR_COLON) begin
                  phase_in = PH_OWS;
               end else begin
                  kind     = KIND_NAME;
                  start    = 1'b1;
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               if (b == CHAR_COLON) begin
                  phase_in = PH_OWS;
               end else if (b == CHAR_CR) begin
                  fail_now  = 1'b1;
                  fail_code = ST_BAD;
               end else begin
                  kind = KIND_NAME;
               end
            end
            PH_OWS: begin
               if (b == CHAR_CR) begin
                  skip_next_in = 1'b1;
                  phase_in     = PH_LINE_START;
               end else if (b != CHAR_SPACE) begin
                  kind          = KIND_VALUE;
                  start         = 1'b1;
                  value_done_in = 1'b0;
                  phase_in      = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (b == CHAR_CR) begin
                  skip_next_in  = 1'b1;
                  value_done_in = 1'b0;
                  phase_in      = PH_LINE_START;
               end else if (b == CHAR_SPACE) begin
                  value_done_in = 1'b1;
               end else if (!value_done_ff) begin
                  kind = KIND_VALUE;
               end
            end
            PH_BODY_FIRST: begin
               kind     = KIND_BODY;
               start    = 1'b1;
               phase_in = PH_BODY;
            end
            PH_BODY: begin
               kind = KIND_BODY;
            end
            default: begin
            end
         endcase
      end

      // first error is kept
      if (fail_now) begin
         phase_in = PH_ERROR;
         if (!err_flag_ff) begin
            err_flag_in = 1'b1;
            err_code_in = fail_code;
         end
      end

      // final status on the last byte
      if (length_in < MIN_LENGTH) begin
         status = ST_BAD;
      end else if (err_flag_in) begin
         status = err_code_in;
      end else if ((phase_in == PH_BODY_FIRST || phase_in == PH_BODY) && !skip_next_in) begin
         status = ST_OK;
      end else if (phase_in == PH_TARGET) begin
         status = ST_TOO_LONG;
      end else begin
         status = ST_BAD;
      end

      result.out_byte     = b;
      result.field_kind   = kind;
      result.field_start  = start;
      result.method_code  = method_in;
      result.status_valid = item.last_byte;
      result.status_code  = item.last_byte ? status : ST_OK;

      // end of message: back to the start
      if (item.last_byte) begin
         phase_in      = PH_METHOD_FIRST;
         match_in      = 4'd0;
         method_in     = METHOD_NONE;
         length_in     = '0;
         err_code_in   = ST_OK;
         err_flag_in   = 1'b0;
         value_done_in = 1'b0;
         skip_next_in  = 1'b0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_METHOD_FIRST;
         match_ff      <= 4'd0;
         method_ff     <= METHOD_NONE;
         length_ff     <= '0;
         err_code_ff   <= ST_OK;
         err_flag_ff   <= 1'b0;
         value_done_ff <= 1'b0;
         skip_next_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         match_ff      <= match_in;
         method_ff     <= method_in;
         length_ff     <= length_in;
         err_code_ff   <= err_code_in;
         err_flag_ff   <= err_flag_in;
         value_done_ff <= value_done_in;
         skip_next_ff  <= skip_next_in;
      end
   end

`ifndef SYNTH
   // last byte returns the parser to its start
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> phase_ff == PH_METHOD_FIRST && length_ff == '0)
      else $error("parser did not restart after the last byte");

   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      length_ff <= MIN_LENGTH)
      else $error("length count past saturation");

   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> err_flag_ff)
      else $error("error phase without a held error");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      !err_flag_ff |-> err_code_ff == ST_OK)
      else $error("error code held without its flag");
`endif
endmodule
`default_nettype wire

FILE: sv/hrsp_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_out_stage
// Result register: holds one tagged byte until the sink takes it.
// ----------------------------------------------------------------------------
module hrsp_out_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire hrsp_pkg::hrsp_result_type result,
   output      logic                      can_take,
   hrsp_rsp_if.source                     rsp_if
);
   import hrsp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   hrsp_result_type result_ff;

   // room for a new result when empty or when the held one leaves now
   assign can_take = !valid_ff || rsp_if.ready;
   assign valid_in = load ? 1'b1 : ((valid_ff && rsp_if.ready) ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   // drive the channel
   assign rsp_if.valid        = valid_ff;
   assign rsp_if.out_byte     = result_ff.out_byte;
   assign rsp_if.field_kind   = result_ff.field_kind;
   assign rsp_if.field_start  = result_ff.field_start;
   assign rsp_if.method_code  = result_ff.method_code;
   assign rsp_if.status_valid = result_ff.status_valid;
   assign rsp_if.status_code  = result_ff.status_code;
endmodule
`default_nettype wire

FILE: tb/http_request_stream_parser_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_stream_parser_core_tb
// Self-checking bench for the request stream parser core.
// ----------------------------------------------------------------------------
// Request messages are built byte by byte and sent over the request channel.
// Most are well-formed, carry random content and are sometimes damaged. The
// rest are short bursts of noise. A parser model inside the bench tags every
// accepted byte and queues the tag it expects. The result side pops and
// compares each tag field by field. Both channels idle at random. One phase
// runs with no idling at all, and another holds the result side off long
// enough to back the core up into its request channel.
// ----------------------------------------------------------------------------
module http_request_stream_parser_core_tb;
   import hrsp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 12;

   logic clock;
   logic reset;

   hrsp_req_if req_ch ();
   hrsp_rsp_if rsp_ch ();

   http_request_stream_parser_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // method words with their trailing space, and the protocol line
   logic [7:0] verb_chars [0:2][0:4] = '{'{"G", "E", "T", " ", 8'h00},
                                        '{"H", "E", "A", "D", " "},
                                        '{"P", "O", "S", "T", " "}};
   logic [3:0] verb_len [0:2] = '{4'd4, 4'd5, 4'd5};
   logic [7:0] proto_chars [0:9] = '{"H", "T", "T", "P", "/", "1", ".", "1",
                                     CHAR_CR, CHAR_LF};

   // parser model state
   logic [3:0] ph;
   logic [3:0] mpos;
   logic [1:0] mseen;
   logic [4:0] lcount;
   logic [1:0] err_code;
   logic       err_flag;
   logic       vdone;
   logic       skip_nxt;

   hrsp_result_type expected_tags [$];
   logic [7:0]      msg_bytes [$];
   int              bytes_sent;
   int              error_count;
   int              cycle_count;
   int              hold_left;
   bit              gaps_on;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // parser model: clear and first error
   task automatic clear_parser();
      ph       = PH_METHOD_FIRST;
      mpos     = 4'd0;
      mseen    = METHOD_NONE;
      lcount   = 5'd0;
      err_code = ST_OK;
      err_flag = 1'b0;
      vdone    = 1'b0;
      skip_nxt = 1'b0;
   endtask

   task automatic raise_error(input logic [1:0] code);
      if (!err_flag) begin
         err_flag = 1'b1;
         err_code = code;
      end
      ph = PH_ERROR;
   endtask

   // parser model: tag one byte and advance
   task automatic predict_tag(input logic [7:0] b, input logic is_last,
                              output hrsp_result_type r);
      logic [2:0] kind;
      logic       start;
      logic [1:0] status;
      logic [1:0] verb;
      logic [3:0] vlen;
      kind   = KIND_SKIP;
      start  = 1'b0;
      status = ST_OK;
      if (lcount < MIN_LENGTH) lcount = lcount + 5'd1;
      if (skip_nxt) begin
         skip_nxt = 1'b0;
      end else begin
         case (ph)
            PH_METHOD_FIRST: begin
               if (b == CHAR_G || b == CHAR_H || b == CHAR_P) begin
                  ph    = (b == CHAR_G) ? PH_M_GET : (b == CHAR_H) ? PH_M_HEAD : PH_M_POST;
                  mpos  = 4'd1;
                  kind  = KIND_METHOD;
                  start = 1'b1;
               end else begin
                  raise_error(ST_NOT_IMPL);
               end
            end
            PH_M_GET, PH_M_HEAD, PH_M_POST: begin
               verb = ph[1:0] - 2'd1;
               vlen = verb_len[verb];
               if (mpos >= vlen || b != verb_chars[verb][mpos]) begin
                  raise_error(ST_NOT_IMPL);
               end else if (mpos == vlen - 4'd1) begin
                  mseen = verb + 2'd1;
                  mpos  = 4'd0;
                  ph    = PH_TARGET_FIRST;
               end else begin
                  mpos = mpos + 4'd1;
                  kind = KIND_METHOD;
               end
            end
            PH_TARGET_FIRST: begin
               if (b == CHAR_SPACE) begin
                  raise_error(ST_BAD);
               end else begin
                  kind  = KIND_TARGET;
                  start = 1'b1;
                  ph    = PH_TARGET;
               end
            end
            PH_TARGET: begin
               if (b == CHAR_SPACE) begin
                  ph   = PH_PROTO;
                  mpos = 4'd0;
               end else begin
                  kind = KIND_TARGET;
               end
            end
            PH_PROTO: begin
               if (mpos > PROTO_LAST_POS || b != proto_chars[mpos]) begin
                  raise_error(ST_BAD);
               end else if (mpos == PROTO_LAST_POS) begin
                  mpos = 4'd0;
                  ph   = PH_LINE_START;
               end else begin
                  mpos = mpos + 4'd1;
               end
            end
            PH_LINE_START: begin
               if (b == CHAR_CR) begin
                  skip_nxt = 1'b1;
                  ph       = PH_BODY_FIRST;
               end else if (b == CHAR_COLON) begin
                  ph = PH_OWS;
               end else begin
                  kind  = KIND_NAME;
                  start = 1'b1;
                  ph    = PH_NAME;
               end
            end
            PH_NAME: begin
               if (b == CHAR_COLON) ph = PH_OWS;
               else if (b == CHAR_CR) raise_error(ST_BAD);
               else kind = KIND_NAME;
            end
            PH_OWS: begin
               if (b == CHAR_CR) begin
                  skip_nxt = 1'b1;
                  ph       = PH_LINE_START;
               end else if (b != CHAR_SPACE) begin
                  kind  = KIND_VALUE;
                  start = 1'b1;
                  vdone = 1'b0;
                  ph    = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (b == CHAR_CR) begin
                  skip_nxt = 1'b1;
                  vdone    = 1'b0;
                  ph       = PH_LINE_START;
               end else if (b == CHAR_SPACE) begin
                  vdone = 1'b1;
               end else if (!vdone) begin
                  kind = KIND_VALUE;
               end
            end
            PH_BODY_FIRST: begin
               kind  = KIND_BODY;
               start = 1'b1;
               ph    = PH_BODY;
            end
            PH_BODY: kind = KIND_BODY;
            default: ;
         endcase
      end
      r.out_byte     = b;
      r.field_kind   = kind;
      r.field_start  = start;
      r.method_code  = mseen;
      r.status_valid = is_last;
      // final status on the last byte, then back to a fresh message
      if (is_last) begin
         if (lcount < MIN_LENGTH) status = ST_BAD;
         else if (err_flag) status = err_code;
         else if ((ph == PH_BODY_FIRST || ph == PH_BODY) && !skip_nxt) status = ST_OK;
         else if (ph == PH_TARGET) status = ST_TOO_LONG;
         else status = ST_BAD;
         clear_parser();
      end
      r.status_code = status;
   endtask

   // offer one byte until it is taken, then queue its expected tag
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      hrsp_result_type want;
      if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= is_last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_tag(b, is_last, want);
      expected_tags.push_back(want);
      bytes_sent++;
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
   endtask

   // message building helpers
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] rand_byte_not(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] b;
      do b = 8'($urandom); while (b == x || b == y);
      return b;
   endfunction

   // mostly a proper line feed after a CR, sometimes any byte
   function automatic logic [7:0] after_cr();
      return ($urandom_range(99) < 85) ? CHAR_LF : 8'($urandom);
   endfunction

   task automatic add_header_line();
      if ($urandom_range(99) < 6) begin
         // line with no colon
         repeat ($urandom_range(1, 4)) msg_bytes.push_back(rand_byte_not(CHAR_COLON, CHAR_CR));
      end else begin
         repeat ($urandom_range(5)) msg_bytes.push_back(rand_byte_not(CHAR_COLON, CHAR_CR));
         msg_bytes.push_back(CHAR_COLON);
         repeat ($urandom_range(2)) msg_bytes.push_back(CHAR_SPACE);
         repeat ($urandom_range(5))
            msg_bytes.push_back(($urandom_range(4) == 0) ? CHAR_SPACE
                                                          : rand_byte_not(CHAR_CR, CHAR_CR));
      end
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(after_cr());
   endtask

   // a request with random content, now and then damaged or cut short
   task automatic build_request();
      int         pick;
      int         keep;
      logic [1:0] verb;
      pick = $urandom_range(99);
      verb = 2'($urandom_range(2));
      if (pick < 5) begin
         repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
      end else begin
         for (int i = 0; i < verb_len[verb]; i++) msg_bytes.push_back(verb_chars[verb][i]);
      end
      // target, empty now and then, long enough at times to end a cut message in it
      if ($urandom_range(99) >= 4)
         repeat ($urandom_range(1, 20)) msg_bytes.push_back(rand_byte_not(CHAR_SPACE, CHAR_SPACE));
      msg_bytes.push_back(CHAR_SPACE);
      push_text("HTTP/1.1");
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(CHAR_LF);
      repeat ($urandom_range(3)) add_header_line();
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(after_cr());
      repeat ($urandom_range(6)) msg_bytes.push_back(8'($urandom));
      // damage: cut short or overwrite one byte
      pick = $urandom_range(99);
      if (pick < 12) begin
         keep = $urandom_range(1, msg_bytes.size());
         while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end else if (pick < 24) begin
         msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom);
      end
   endtask

   task automatic build_random_message();
      if ($urandom_range(99) < 10) begin
         repeat ($urandom_range(1, 20)) msg_bytes.push_back(8'($urandom));
      end else begin
         build_request();
      end
   endtask

   // result side: compare with the oldest expected tag, then pick ready
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      hrsp_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_tags.size() == 0) begin
               $error("result byte %0h with no request outstanding", rsp_ch.out_byte);
               error_count++;
            end else begin
               want = expected_tags.pop_front();
               check_field("out_byte", want.out_byte, rsp_ch.out_byte);
               check_field("field_kind", want.field_kind, rsp_ch.field_kind);
               check_field("field_start", want.field_start, rsp_ch.field_start);
               check_field("method_code", want.method_code, rsp_ch.method_code);
               check_field("status_valid", want.status_valid, rsp_ch.status_valid);
               check_field("status_code", want.status_code, rsp_ch.status_code);
            end
         end
         // long hold-off when asked, otherwise random stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // tests
   task automatic test_directed();
      // minimal well-formed GET with an empty header block
      push_text("GET / HTTP/1.1");
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(CHAR_LF);
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(CHAR_LF);
      send_message();
      // single-byte messages at both byte extremes
      msg_bytes.push_back(8'hFF);
      send_message();
      msg_bytes.push_back(8'h00);
      send_message();
      // empty target, too short as well
      push_text("HEAD  ");
      send_message();
   endtask

   task automatic test_random_requests(input int count);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         build_random_message();
         send_message();
      end
   endtask

   task automatic test_steady_stream(input int count);
      gaps_on = 1'b0;
      test_random_requests(count);
      gaps_on = 1'b1;
   endtask

   task automatic test_output_holdoff(input int count);
      hold_left = 90;
      test_random_requests(count);
   endtask

   // main sequence
   initial begin
      bytes_sent   = 0;
      error_count  = 0;
      hold_left    = 0;
      gaps_on      = 1'b1;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_requests(1100);
      test_steady_stream(400);
      test_output_holdoff(380);

      req_ch.valid <= 1'b0;
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
sv/hrsp_pkg.sv
sv/hrsp_req_if.sv
sv/hrsp_rsp_if.sv
sv/hrsp_in_stage.sv
sv/hrsp_fsm.sv
sv/hrsp_out_stage.sv
sv/http_request_stream_parser_core.sv
tb/http_request_stream_parser_core_tb.sv
